/* hw/rtl/usrh_pkg.sv */
// shared types, codes and helpers for the usb standard request handler
`default_nettype none
package usrh_pkg;

  localparam int MaxStringsDefault = 8;

  localparam int CfgDataWidth = 64;
  localparam int CfgAddrWidth = 6;

  typedef enum logic [1:0] {
    ST_UNKNOWN = 2'd0,
    ST_HANDLED = 2'd1,
    ST_STALL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SRC_NONE      = 3'd0,
    SRC_INLINE    = 3'd1,
    SRC_DEVICE    = 3'd2,
    SRC_CONFIG    = 3'd3,
    SRC_STRING    = 3'd4,
    SRC_QUALIFIER = 3'd5
  } source_t;

  typedef enum logic [1:0] {
    DEV_DEFAULT    = 2'd0,
    DEV_ADDRESSED  = 2'd1,
    DEV_CONFIGURED = 2'd2
  } dev_state_t;

  typedef enum logic [1:0] {
    EV_NONE         = 2'd0,
    EV_CONFIGURED   = 2'd1,
    EV_DECONFIGURED = 2'd2
  } event_t;

  localparam logic [7:0] RQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] RQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] RQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] RQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] RQ_SET_CONFIG        = 8'd9;
  localparam logic [7:0] RQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] RQ_SET_INTERFACE     = 8'd11;

  localparam logic [7:0] DT_DEVICE    = 8'd1;
  localparam logic [7:0] DT_CONFIG    = 8'd2;
  localparam logic [7:0] DT_STRING    = 8'd3;
  localparam logic [7:0] DT_QUALIFIER = 8'd6;

  localparam logic [15:0] LEN_DEVICE    = 16'd18;
  localparam logic [15:0] LEN_CONFIG    = 16'd9;
  localparam logic [15:0] LEN_QUALIFIER = 16'd10;

  localparam logic [4:0] RCPT_INTERFACE = 5'd1;

  // configuration register indexes
  localparam logic [2:0] REG_CFG_NUMBER   = 3'd0;
  localparam logic [2:0] REG_CFG_COUNT    = 3'd1;
  localparam logic [2:0] REG_STR_COUNT    = 3'd2;
  localparam logic [2:0] REG_INTF_NUMBER  = 3'd3;
  localparam logic [2:0] REG_ALT_SETTING  = 3'd4;
  localparam logic [2:0] REG_TOTAL_LENGTH = 3'd5;
  localparam logic [2:0] REG_STR_LENGTHS  = 3'd6;

  typedef struct packed {
    logic [7:0]  configuration_number;
    logic [7:0]  configuration_count;
    logic [3:0]  string_count;
    logic [7:0]  interface_number;
    logic [7:0]  alternate_setting_value;
    logic [15:0] configuration_total_length;
    logic [63:0] string_lengths;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] request_length;
  } setup_t;

  typedef struct packed {
    status_t     status;
    source_t     reply_source;
    logic [7:0]  source_index;
    logic [15:0] transfer_length;
    logic [15:0] reply_data;
    logic [15:0] continuation_length;
    event_t      state_event;
    dev_state_t  previous_state;
  } result_t;

  function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/usrh_setup_if.sv */
// setup packet channel
`default_nettype none
interface usrh_setup_if;
  logic        valid;
  logic        ready;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] value_word;
  logic [15:0] index_word;
  logic [15:0] request_length;

  modport source (
    output valid, request_type, request_code, value_word, index_word, request_length,
    input  ready
  );
  modport sink (
    input  valid, request_type, request_code, value_word, index_word, request_length,
    output ready
  );
endinterface
`default_nettype wire

/* hw/rtl/usrh_result_if.sv */
// request result channel
`default_nettype none
interface usrh_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  reply_source;
  logic [7:0]  source_index;
  logic [15:0] transfer_length;
  logic [15:0] reply_data;
  logic [15:0] continuation_length;
  logic [1:0]  state_event;
  logic [1:0]  previous_state;

  modport source (
    output valid, status, reply_source, source_index, transfer_length, reply_data,
           continuation_length, state_event, previous_state,
    input  ready
  );
  modport sink (
    input  valid, status, reply_source, source_index, transfer_length, reply_data,
           continuation_length, state_event, previous_state,
    output ready
  );
endinterface
`default_nettype wire

/* hw/rtl/usrh_cfg_regs.sv */
// apb configuration registers
`default_nettype none
module usrh_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [usrh_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [usrh_pkg::CfgDataWidth-1:0] pwdata,
  output logic      [usrh_pkg::CfgDataWidth-1:0] prdata,
  output logic                                 pready,
  output usrh_pkg::cfg_regs_t                  cfg
);

  usrh_pkg::cfg_regs_t cfg_r;
  usrh_pkg::cfg_regs_t cfg_nxt;
  logic [2:0]          reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        usrh_pkg::REG_CFG_NUMBER:   cfg_nxt.configuration_number = pwdata[7:0];
        usrh_pkg::REG_CFG_COUNT:    cfg_nxt.configuration_count = pwdata[7:0];
        usrh_pkg::REG_STR_COUNT:    cfg_nxt.string_count = pwdata[3:0];
        usrh_pkg::REG_INTF_NUMBER:  cfg_nxt.interface_number = pwdata[7:0];
        usrh_pkg::REG_ALT_SETTING:  cfg_nxt.alternate_setting_value = pwdata[7:0];
        usrh_pkg::REG_TOTAL_LENGTH: cfg_nxt.configuration_total_length = pwdata[15:0];
        usrh_pkg::REG_STR_LENGTHS:  cfg_nxt.string_lengths = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.configuration_number       <= 8'd1;
      cfg_r.configuration_count        <= 8'd1;
      cfg_r.string_count               <= 4'd0;
      cfg_r.interface_number           <= 8'd0;
      cfg_r.alternate_setting_value    <= 8'd0;
      cfg_r.configuration_total_length <= 16'd9;
      cfg_r.string_lengths             <= 64'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      usrh_pkg::REG_CFG_NUMBER:   prdata = {56'd0, cfg_r.configuration_number};
      usrh_pkg::REG_CFG_COUNT:    prdata = {56'd0, cfg_r.configuration_count};
      usrh_pkg::REG_STR_COUNT:    prdata = {60'd0, cfg_r.string_count};
      usrh_pkg::REG_INTF_NUMBER:  prdata = {56'd0, cfg_r.interface_number};
      usrh_pkg::REG_ALT_SETTING:  prdata = {56'd0, cfg_r.alternate_setting_value};
      usrh_pkg::REG_TOTAL_LENGTH: prdata = {48'd0, cfg_r.configuration_total_length};
      usrh_pkg::REG_STR_LENGTHS:  prdata = cfg_r.string_lengths;
      default:                    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/usrh_decode.sv */
// combinational decode of one setup packet against the current device state
`default_nettype none
module usrh_decode #(
  parameter int MAX_STRINGS = usrh_pkg::MaxStringsDefault
) (
  input  usrh_pkg::setup_t     setup,
  input  usrh_pkg::cfg_regs_t  cfg,
  input  usrh_pkg::dev_state_t dev_state,
  output usrh_pkg::result_t    res,
  output logic                 state_wr,
  output usrh_pkg::dev_state_t state_nxt
);

  localparam logic [7:0] MaxStr = 8'(MAX_STRINGS);

  logic [7:0]  vlo;
  logic [7:0]  vhi;
  logic [7:0]  ilo;
  logic [15:0] wlen;
  logic        dir_in;
  logic        to_intf;
  logic        configured;
  logic [15:0] total;
  logic [15:0] cfg_tlen;
  logic [7:0]  slen;
  logic        str_ok;

  assign vlo        = setup.value_word[7:0];
  assign vhi        = setup.value_word[15:8];
  assign ilo        = setup.index_word[7:0];
  assign wlen       = setup.request_length;
  assign dir_in     = setup.request_type[7];
  assign to_intf    = setup.request_type[4:0] == usrh_pkg::RCPT_INTERFACE;
  assign configured = dev_state == usrh_pkg::DEV_CONFIGURED;

  // short totals are read as a bare configuration header
  assign total    = (cfg.configuration_total_length < usrh_pkg::LEN_CONFIG) ?
                    usrh_pkg::LEN_CONFIG : cfg.configuration_total_length;
  assign cfg_tlen = usrh_pkg::min16(wlen, total);
  assign slen     = cfg.string_lengths[{vlo[2:0], 3'b000} +: 8];
  assign str_ok   = (vlo < {4'd0, cfg.string_count}) && (vlo < MaxStr) && (vlo < 8'd8);

  always_comb begin
    res                     = '0;
    res.status              = usrh_pkg::ST_UNKNOWN;
    res.reply_source        = usrh_pkg::SRC_NONE;
    res.state_event         = usrh_pkg::EV_NONE;
    res.previous_state      = dev_state;
    state_wr                = 1'b0;
    state_nxt               = dev_state;
    case (setup.request_code)
      usrh_pkg::RQ_CLEAR_FEATURE, usrh_pkg::RQ_SET_FEATURE: begin
        if (to_intf) begin
          res.status = (wlen == 16'd0 && configured && vlo == 8'd0 &&
                        ilo == cfg.interface_number) ?
                       usrh_pkg::ST_HANDLED : usrh_pkg::ST_STALL;
        end
      end
      usrh_pkg::RQ_GET_CONFIGURATION: begin
        if (wlen == 16'd1 && dir_in) begin
          res.status          = usrh_pkg::ST_HANDLED;
          res.reply_source    = usrh_pkg::SRC_INLINE;
          res.transfer_length = 16'd1;
          res.reply_data      = configured ? {8'd0, cfg.configuration_number} : 16'd0;
        end else begin
          res.status = usrh_pkg::ST_STALL;
        end
      end
      usrh_pkg::RQ_GET_DESCRIPTOR: begin
        if (wlen == 16'd0 || !dir_in) begin
          res.status = usrh_pkg::ST_STALL;
        end else if (vhi == usrh_pkg::DT_DEVICE) begin
          res.status          = usrh_pkg::ST_HANDLED;
          res.reply_source    = usrh_pkg::SRC_DEVICE;
          res.transfer_length = usrh_pkg::min16(wlen, usrh_pkg::LEN_DEVICE);
        end else if (vhi == usrh_pkg::DT_CONFIG) begin
          if (vlo >= cfg.configuration_count) begin
            res.status = usrh_pkg::ST_STALL;
          end else begin
            res.status              = usrh_pkg::ST_HANDLED;
            res.reply_source        = usrh_pkg::SRC_CONFIG;
            res.source_index        = vlo;
            res.transfer_length     = cfg_tlen;
            res.continuation_length = (cfg_tlen > usrh_pkg::LEN_CONFIG) ?
                                      cfg_tlen - usrh_pkg::LEN_CONFIG : 16'd0;
          end
        end else if (vhi == usrh_pkg::DT_STRING) begin
          if (!str_ok) begin
            res.status = usrh_pkg::ST_STALL;
          end else begin
            res.status          = usrh_pkg::ST_HANDLED;
            res.reply_source    = usrh_pkg::SRC_STRING;
            res.source_index    = vlo;
            res.transfer_length = usrh_pkg::min16(wlen, {8'd0, slen});
          end
        end else if (vhi == usrh_pkg::DT_QUALIFIER) begin
          res.status          = usrh_pkg::ST_HANDLED;
          res.reply_source    = usrh_pkg::SRC_QUALIFIER;
          res.transfer_length = usrh_pkg::min16(wlen, usrh_pkg::LEN_QUALIFIER);
        end else begin
          res.status = usrh_pkg::ST_STALL;
        end
      end
      usrh_pkg::RQ_GET_INTERFACE: begin
        if (wlen != 16'd1 || !dir_in || !configured ||
            setup.index_word != {8'd0, cfg.interface_number}) begin
          res.status = usrh_pkg::ST_STALL;
        end else begin
          res.status          = usrh_pkg::ST_HANDLED;
          res.reply_source    = usrh_pkg::SRC_INLINE;
          res.transfer_length = 16'd1;
          res.reply_data      = {8'd0, cfg.alternate_setting_value};
        end
      end
      usrh_pkg::RQ_GET_STATUS: begin
        if (to_intf) begin
          if (wlen == 16'd2 && dir_in && configured && ilo == cfg.interface_number) begin
            res.status          = usrh_pkg::ST_HANDLED;
            res.reply_source    = usrh_pkg::SRC_INLINE;
            res.transfer_length = 16'd2;
          end else begin
            res.status = usrh_pkg::ST_STALL;
          end
        end
      end
      usrh_pkg::RQ_SET_CONFIG: begin
        // zero deconfigures even when it equals the configuration id
        if (vlo == 8'd0) begin
          res.status      = usrh_pkg::ST_HANDLED;
          res.state_event = usrh_pkg::EV_DECONFIGURED;
          state_wr        = 1'b1;
          state_nxt       = usrh_pkg::DEV_ADDRESSED;
        end else if (vlo == cfg.configuration_number) begin
          res.status      = usrh_pkg::ST_HANDLED;
          res.state_event = usrh_pkg::EV_CONFIGURED;
          state_wr        = 1'b1;
          state_nxt       = usrh_pkg::DEV_CONFIGURED;
        end else begin
          res.status = usrh_pkg::ST_STALL;
        end
      end
      usrh_pkg::RQ_SET_INTERFACE: begin
        res.status = usrh_pkg::ST_HANDLED;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/usb_standard_request_handler.sv */
// Standard device request handler: decodes one USB setup packet per transfer on the
// input channel and returns one result per packet, in order. A packet is captured in
// an input register, decoded combinationally against the device state and configuration
// registers, and lands in a result register, so the block sustains one packet per clock
// while the output side is not stalled, and each result is offered from that register.
// The device state (default, addressed, configured) starts at default after reset and is
// changed only by the set-config request. Configuration registers sit on a 64-bit APB
// port at byte address 8*index and should be written only while no packet is in flight;
// pready is always high.
`default_nettype none
module usb_standard_request_handler #(
  parameter int MAX_STRINGS = usrh_pkg::MaxStringsDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  usrh_setup_if.sink                             in_if,
  usrh_result_if.source                          out_if,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [usrh_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [usrh_pkg::CfgDataWidth-1:0] pwdata,
  output logic      [usrh_pkg::CfgDataWidth-1:0] prdata,
  output logic                                   pready
);

  usrh_pkg::cfg_regs_t  cfg;
  usrh_pkg::setup_t     setup_r;
  logic                 setup_vld_r;
  usrh_pkg::result_t    res_r;
  usrh_pkg::result_t    res_nxt;
  logic                 res_vld_r;
  usrh_pkg::dev_state_t dev_state_r;
  usrh_pkg::dev_state_t dev_state_nxt;
  logic                 state_wr;
  logic                 res_free;
  logic                 advance;
  logic                 in_take;

  usrh_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  usrh_decode #(
    .MAX_STRINGS (MAX_STRINGS)
  ) u_decode (
    .setup     (setup_r),
    .cfg       (cfg),
    .dev_state (dev_state_r),
    .res       (res_nxt),
    .state_wr  (state_wr),
    .state_nxt (dev_state_nxt)
  );

  assign res_free    = !res_vld_r || out_if.ready;
  assign advance     = setup_vld_r && res_free;
  assign in_if.ready = !setup_vld_r || res_free;
  assign in_take     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_vld_r <= 1'b0;
      res_vld_r   <= 1'b0;
      dev_state_r <= usrh_pkg::DEV_DEFAULT;
    end else begin
      if (in_take) begin
        setup_vld_r <= 1'b1;
      end else if (advance) begin
        setup_vld_r <= 1'b0;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        res_vld_r <= 1'b0;
      end
      // state moves when the packet that changes it goes to the result register
      if (advance && state_wr) begin
        dev_state_r <= dev_state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      setup_r.request_type   <= in_if.request_type;
      setup_r.request_code   <= in_if.request_code;
      setup_r.value_word     <= in_if.value_word;
      setup_r.index_word     <= in_if.index_word;
      setup_r.request_length <= in_if.request_length;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid               = res_vld_r;
  assign out_if.status              = res_r.status;
  assign out_if.reply_source        = res_r.reply_source;
  assign out_if.source_index        = res_r.source_index;
  assign out_if.transfer_length     = res_r.transfer_length;
  assign out_if.reply_data          = res_r.reply_data;
  assign out_if.continuation_length = res_r.continuation_length;
  assign out_if.state_event         = res_r.state_event;
  assign out_if.previous_state      = res_r.previous_state;

endmodule
`default_nettype wire

/* dv/usrh_reply_checker.sv */
`timescale 1ns / 1ps
// reply checker: mirrors register writes and device state, predicts each reply, compares
module usrh_reply_checker #(
  parameter int MAX_STRINGS = usrh_pkg::MaxStringsDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  usrh_setup_if                             setup_mon,
  usrh_result_if                            result_mon,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [usrh_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [usrh_pkg::CfgDataWidth-1:0] pwdata,
  output int                                fail_count,
  output int                                outstanding
);

  usrh_pkg::cfg_regs_t  shadow_regs;
  usrh_pkg::dev_state_t dev_state;
  usrh_pkg::result_t    expected_replies[$];
  int                   n_fail = 0;
  int                   n_pending = 0;

  assign fail_count  = n_fail;
  assign outstanding = n_pending;

  function automatic logic [15:0] clip_len(input logic [15:0] asked, input logic [15:0] avail);
    return (asked < avail) ? asked : avail;
  endfunction

  function automatic usrh_pkg::result_t predict_reply(input usrh_pkg::setup_t pkt,
                                                      input usrh_pkg::cfg_regs_t regs,
                                                      input usrh_pkg::dev_state_t now);
    usrh_pkg::result_t r;
    logic [7:0]        vlo;
    logic [7:0]        vhi;
    logic [7:0]        ilo;
    logic              dir_in;
    logic              to_intf;
    logic              configured;
    logic [15:0]       total;
    vlo        = pkt.value_word[7:0];
    vhi        = pkt.value_word[15:8];
    ilo        = pkt.index_word[7:0];
    dir_in     = pkt.request_type[7];
    to_intf    = pkt.request_type[4:0] == usrh_pkg::RCPT_INTERFACE;
    configured = now == usrh_pkg::DEV_CONFIGURED;
    r = '0;
    r.previous_state = now;
    case (pkt.request_code)
      usrh_pkg::RQ_CLEAR_FEATURE, usrh_pkg::RQ_SET_FEATURE: begin
        if (to_intf) begin
          if (pkt.request_length == 16'd0 && configured && vlo == 8'd0 &&
              ilo == regs.interface_number)
            r.status = usrh_pkg::ST_HANDLED;
          else
            r.status = usrh_pkg::ST_STALL;
        end
      end
      usrh_pkg::RQ_GET_CONFIGURATION: begin
        if (pkt.request_length == 16'd1 && dir_in) begin
          r.status          = usrh_pkg::ST_HANDLED;
          r.reply_source    = usrh_pkg::SRC_INLINE;
          r.transfer_length = 16'd1;
          r.reply_data      = configured ? {8'd0, regs.configuration_number} : 16'd0;
        end else begin
          r.status = usrh_pkg::ST_STALL;
        end
      end
      usrh_pkg::RQ_GET_DESCRIPTOR: begin
        if (pkt.request_length == 16'd0 || !dir_in) begin
          r.status = usrh_pkg::ST_STALL;
        end else if (vhi == usrh_pkg::DT_DEVICE) begin
          r.status          = usrh_pkg::ST_HANDLED;
          r.reply_source    = usrh_pkg::SRC_DEVICE;
          r.transfer_length = clip_len(pkt.request_length, usrh_pkg::LEN_DEVICE);
        end else if (vhi == usrh_pkg::DT_CONFIG) begin
          if (vlo >= regs.configuration_count) begin
            r.status = usrh_pkg::ST_STALL;
          end else begin
            // a total below the header size still covers the header
            total = (regs.configuration_total_length < usrh_pkg::LEN_CONFIG) ?
                    usrh_pkg::LEN_CONFIG : regs.configuration_total_length;
            r.status              = usrh_pkg::ST_HANDLED;
            r.reply_source        = usrh_pkg::SRC_CONFIG;
            r.source_index        = vlo;
            r.transfer_length     = clip_len(pkt.request_length, total);
            r.continuation_length = (r.transfer_length > usrh_pkg::LEN_CONFIG) ?
                                    r.transfer_length - usrh_pkg::LEN_CONFIG : 16'd0;
          end
        end else if (vhi == usrh_pkg::DT_STRING) begin
          if (vlo >= {4'd0, regs.string_count} || vlo >= MAX_STRINGS || vlo >= 8) begin
            r.status = usrh_pkg::ST_STALL;
          end else begin
            r.status          = usrh_pkg::ST_HANDLED;
            r.reply_source    = usrh_pkg::SRC_STRING;
            r.source_index    = vlo;
            r.transfer_length = clip_len(pkt.request_length,
                                         {8'd0, regs.string_lengths[{vlo[2:0], 3'b000} +: 8]});
          end
        end else if (vhi == usrh_pkg::DT_QUALIFIER) begin
          r.status          = usrh_pkg::ST_HANDLED;
          r.reply_source    = usrh_pkg::SRC_QUALIFIER;
          r.transfer_length = clip_len(pkt.request_length, usrh_pkg::LEN_QUALIFIER);
        end else begin
          r.status = usrh_pkg::ST_STALL;
        end
      end
      usrh_pkg::RQ_GET_INTERFACE: begin
        if (pkt.request_length != 16'd1 || !dir_in || !configured ||
            pkt.index_word != {8'd0, regs.interface_number}) begin
          r.status = usrh_pkg::ST_STALL;
        end else begin
          r.status          = usrh_pkg::ST_HANDLED;
          r.reply_source    = usrh_pkg::SRC_INLINE;
          r.transfer_length = 16'd1;
          r.reply_data      = {8'd0, regs.alternate_setting_value};
        end
      end
      usrh_pkg::RQ_GET_STATUS: begin
        if (to_intf) begin
          if (pkt.request_length == 16'd2 && dir_in && configured &&
              ilo == regs.interface_number) begin
            r.status          = usrh_pkg::ST_HANDLED;
            r.reply_source    = usrh_pkg::SRC_INLINE;
            r.transfer_length = 16'd2;
          end else begin
            r.status = usrh_pkg::ST_STALL;
          end
        end
      end
      usrh_pkg::RQ_SET_CONFIG: begin
        // zero wins even when the configuration id is zero
        if (vlo == 8'd0) begin
          r.status      = usrh_pkg::ST_HANDLED;
          r.state_event = usrh_pkg::EV_DECONFIGURED;
        end else if (vlo == regs.configuration_number) begin
          r.status      = usrh_pkg::ST_HANDLED;
          r.state_event = usrh_pkg::EV_CONFIGURED;
        end else begin
          r.status = usrh_pkg::ST_STALL;
        end
      end
      usrh_pkg::RQ_SET_INTERFACE: r.status = usrh_pkg::ST_HANDLED;
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : monitor
    usrh_pkg::result_t want;
    usrh_pkg::setup_t  pkt;
    if (!rst_n) begin
      shadow_regs = '0;
      shadow_regs.configuration_number       = 8'd1;
      shadow_regs.configuration_count        = 8'd1;
      shadow_regs.configuration_total_length = usrh_pkg::LEN_CONFIG;
      dev_state = usrh_pkg::DEV_DEFAULT;
      expected_replies.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply transfer with no setup packet outstanding");
          n_fail++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 16'(want.status), 16'(result_mon.status));
          check_field("reply_source", 16'(want.reply_source), 16'(result_mon.reply_source));
          check_field("source_index", 16'(want.source_index), 16'(result_mon.source_index));
          check_field("transfer_length", want.transfer_length, result_mon.transfer_length);
          check_field("reply_data", want.reply_data, result_mon.reply_data);
          check_field("continuation_length", want.continuation_length,
                      result_mon.continuation_length);
          check_field("state_event", 16'(want.state_event), 16'(result_mon.state_event));
          check_field("previous_state", 16'(want.previous_state),
                      16'(result_mon.previous_state));
        end
      end
      if (setup_mon.valid && setup_mon.ready) begin
        pkt = {setup_mon.request_type, setup_mon.request_code, setup_mon.value_word,
               setup_mon.index_word, setup_mon.request_length};
        want = predict_reply(pkt, shadow_regs, dev_state);
        case (want.state_event)
          usrh_pkg::EV_CONFIGURED:   dev_state = usrh_pkg::DEV_CONFIGURED;
          usrh_pkg::EV_DECONFIGURED: dev_state = usrh_pkg::DEV_ADDRESSED;
          default: ;
        endcase
        expected_replies.push_back(want);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[usrh_pkg::CfgAddrWidth-1:3])
          usrh_pkg::REG_CFG_NUMBER:
            shadow_regs.configuration_number = pwdata[7:0];
          usrh_pkg::REG_CFG_COUNT:
            shadow_regs.configuration_count = pwdata[7:0];
          usrh_pkg::REG_STR_COUNT:
            shadow_regs.string_count = pwdata[3:0];
          usrh_pkg::REG_INTF_NUMBER:
            shadow_regs.interface_number = pwdata[7:0];
          usrh_pkg::REG_ALT_SETTING:
            shadow_regs.alternate_setting_value = pwdata[7:0];
          usrh_pkg::REG_TOTAL_LENGTH:
            shadow_regs.configuration_total_length = pwdata[15:0];
          usrh_pkg::REG_STR_LENGTHS:
            shadow_regs.string_lengths = pwdata;
          default: ;
        endcase
      end
    end
    n_pending <= expected_replies.size();
  end

endmodule

/* dv/tb_usb_standard_request_handler.sv */
`timescale 1ns / 1ps
// testbench top: setup packet and register stimulus, handshake idling, verdict
module tb_usb_standard_request_handler;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 64;
  localparam int RandomPhases  = 6;
  localparam int PhaseItems    = 255;

  localparam logic [7:0] RT_DEV_IN    = 8'h80;
  localparam logic [7:0] RT_DEV_OUT   = 8'h00;
  localparam logic [7:0] RT_INTF_IN   = 8'h81;
  localparam logic [7:0] RT_INTF_OUT  = 8'h01;
  localparam logic [7:0] RQ_UNDEFINED = 8'hFF;
  localparam logic [7:0] DT_INTERFACE = 8'd4;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [5:0]          paddr;
  logic [63:0]         pwdata;
  logic [63:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  outstanding;
  int                  stall_cycles = 0;
  bit                  idle_in = 1'b1;
  bit                  idle_out = 1'b1;
  bit                  hold_req = 1'b0;
  usrh_pkg::cfg_regs_t cur_cfg;

  usrh_setup_if  setup_ch();
  usrh_result_if result_ch();

  usb_standard_request_handler i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (setup_ch),
    .out_if  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  usrh_reply_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .setup_mon   (setup_ch),
    .result_mon  (result_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (setup_ch.valid && setup_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic usrh_pkg::setup_t mk_setup(input logic [7:0] rtype,
                                                input logic [7:0] code,
                                                input logic [15:0] wvalue,
                                                input logic [15:0] windex,
                                                input logic [15:0] wlen);
    usrh_pkg::setup_t s;
    s.request_type   = rtype;
    s.request_code   = code;
    s.value_word     = wvalue;
    s.index_word     = windex;
    s.request_length = wlen;
    return s;
  endfunction

  function automatic logic [15:0] rand_len();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 3));
      1:       return 16'($urandom_range(1, 40));
      2:       return 16'($urandom_range(1, 400));
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic usrh_pkg::cfg_regs_t rand_cfg();
    usrh_pkg::cfg_regs_t c;
    c.configuration_number    = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) :
                                                            8'($urandom_range(1, 4));
    c.configuration_count     = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) :
                                                            8'($urandom_range(0, 12));
    c.string_count            = 4'($urandom_range(0, 8));
    c.interface_number        = 8'($urandom_range(0, 255));
    c.alternate_setting_value = 8'($urandom_range(0, 255));
    c.configuration_total_length = $urandom_range(0, 1) ? 16'($urandom_range(9, 600)) :
                                                         16'($urandom_range(9, 65535));
    c.string_lengths          = {$urandom, $urandom};
    return c;
  endfunction

  // mostly well-formed requests against the current registers, some broken, some noise
  function automatic usrh_pkg::setup_t rand_setup();
    usrh_pkg::setup_t s;
    logic [7:0]       dtype;
    s = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return s;
    s.value_word = 16'd0;
    s.index_word = {8'd0, cur_cfg.interface_number};
    case ($urandom_range(0, 11))
      0: begin
        s.request_type   = RT_INTF_IN;
        s.request_code   = usrh_pkg::RQ_GET_STATUS;
        s.request_length = 16'd2;
      end
      1, 2: begin
        s.request_type   = RT_INTF_OUT;
        s.request_code   = $urandom_range(0, 1) ? usrh_pkg::RQ_SET_FEATURE :
                                                  usrh_pkg::RQ_CLEAR_FEATURE;
        s.request_length = 16'd0;
      end
      3, 4, 5, 6: begin
        case ($urandom_range(0, 9))
          0, 1:    dtype = usrh_pkg::DT_DEVICE;
          2, 3, 4: dtype = usrh_pkg::DT_CONFIG;
          5, 6, 7: dtype = usrh_pkg::DT_STRING;
          8:       dtype = usrh_pkg::DT_QUALIFIER;
          default: dtype = 8'($urandom);
        endcase
        s.request_type   = RT_DEV_IN;
        s.request_code   = usrh_pkg::RQ_GET_DESCRIPTOR;
        s.value_word     = {dtype, $urandom_range(0, 7) == 0 ? 8'($urandom) :
                                                               8'($urandom_range(0, 9))};
        s.index_word     = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
        s.request_length = rand_len();
      end
      7: begin
        s.request_type   = RT_DEV_IN;
        s.request_code   = usrh_pkg::RQ_GET_CONFIGURATION;
        s.request_length = 16'd1;
      end
      8, 9: begin
        s.request_type = RT_DEV_OUT;
        s.request_code = usrh_pkg::RQ_SET_CONFIG;
        case ($urandom_range(0, 3))
          0:       s.value_word = 16'd0;
          1:       s.value_word = 16'($urandom);
          default: s.value_word = {8'd0, cur_cfg.configuration_number};
        endcase
        s.request_length = 16'd0;
      end
      10: begin
        s.request_type   = RT_INTF_IN;
        s.request_code   = usrh_pkg::RQ_GET_INTERFACE;
        s.request_length = 16'd1;
      end
      default: begin
        s.request_type   = RT_INTF_OUT;
        s.request_code   = usrh_pkg::RQ_SET_INTERFACE;
        s.value_word     = 16'($urandom_range(0, 3));
        s.request_length = 16'd0;
      end
    endcase
    // occasional damage to an otherwise well-formed request
    if ($urandom_range(0, 9) == 0) s.request_type = 8'($urandom);
    if ($urandom_range(0, 9) == 0) s.request_length = rand_len();
    if ($urandom_range(0, 9) == 0) s.value_word[7:0] = 8'($urandom);
    if ($urandom_range(0, 9) == 0) s.index_word = 16'($urandom);
    return s;
  endfunction

  // called just after the clock rises; returns when the packet has been taken
  task automatic put_setup(input usrh_pkg::setup_t s);
    int gap;
    gap = idle_in ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      setup_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    setup_ch.valid <= 1'b1;
    {setup_ch.request_type, setup_ch.request_code, setup_ch.value_word,
     setup_ch.index_word, setup_ch.request_length} <= s;
    @(posedge clk);
    while (!setup_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input usrh_pkg::cfg_regs_t c);
    cur_cfg = c;
    write_reg(usrh_pkg::REG_CFG_NUMBER, {56'd0, c.configuration_number});
    write_reg(usrh_pkg::REG_CFG_COUNT, {56'd0, c.configuration_count});
    write_reg(usrh_pkg::REG_STR_COUNT, {60'd0, c.string_count});
    write_reg(usrh_pkg::REG_INTF_NUMBER, {56'd0, c.interface_number});
    write_reg(usrh_pkg::REG_ALT_SETTING, {56'd0, c.alternate_setting_value});
    write_reg(usrh_pkg::REG_TOTAL_LENGTH, {48'd0, c.configuration_total_length});
    write_reg(usrh_pkg::REG_STR_LENGTHS, c.string_lengths);
  endtask

  // stop offering and wait for every reply, then let the pipeline settle
  task automatic drain();
    setup_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : result_sink
    int gap;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HoldCycles;
      end else begin
        gap = idle_out ? $urandom_range(0, 4) : 0;
      end
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    usrh_pkg::cfg_regs_t c;
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    setup_ch.valid <= 1'b0;
    {setup_ch.request_type, setup_ch.request_code, setup_ch.value_word,
     setup_ch.index_word, setup_ch.request_length} <= '0;
    cur_cfg = '0;
    cur_cfg.configuration_number       = 8'd1;
    cur_cfg.configuration_count        = 8'd1;
    cur_cfg.configuration_total_length = usrh_pkg::LEN_CONFIG;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, device starts in default state
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd1));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_DESCRIPTOR, {usrh_pkg::DT_CONFIG, 8'd0},
                       16'd0, 16'hFFFF));
    put_setup(mk_setup(RT_DEV_OUT, usrh_pkg::RQ_SET_CONFIG, 16'd1, 16'd0, 16'd0));
    put_setup(mk_setup(RT_DEV_OUT, usrh_pkg::RQ_SET_CONFIG, 16'd0, 16'd0, 16'd0));
    drain();

    c.configuration_number       = 8'd5;
    c.configuration_count        = 8'd3;
    c.string_count               = 4'd4;
    c.interface_number           = 8'd2;
    c.alternate_setting_value    = 8'hA5;
    c.configuration_total_length = 16'd300;
    c.string_lengths             = 64'h0000_0000_0022_1A04;
    program_regs(c);
    // addressed, not configured: interface requests stall
    put_setup(mk_setup(RT_INTF_IN, usrh_pkg::RQ_GET_INTERFACE, 16'd0, 16'd2, 16'd1));
    put_setup(mk_setup(RT_INTF_IN, usrh_pkg::RQ_GET_STATUS, 16'd0, 16'd2, 16'd2));
    put_setup(mk_setup(RT_INTF_OUT, usrh_pkg::RQ_SET_FEATURE, 16'd0, 16'd2, 16'd0));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
    put_setup(mk_setup(RT_DEV_IN, RQ_UNDEFINED, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    put_setup(mk_setup(RT_DEV_OUT, usrh_pkg::RQ_SET_CONFIG, 16'd7, 16'd0, 16'd0));
    put_setup(mk_setup(RT_DEV_OUT, usrh_pkg::RQ_SET_CONFIG, 16'hFF05, 16'd0, 16'd0));
    // configuring again still reports the event
    put_setup(mk_setup(RT_DEV_OUT, usrh_pkg::RQ_SET_CONFIG, 16'd5, 16'd0, 16'd0));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd1));
    put_setup(mk_setup(RT_INTF_IN, usrh_pkg::RQ_GET_INTERFACE, 16'd0, 16'd2, 16'd1));
    put_setup(mk_setup(RT_INTF_IN, usrh_pkg::RQ_GET_INTERFACE, 16'd0, 16'h0102, 16'd1));
    put_setup(mk_setup(RT_INTF_IN, usrh_pkg::RQ_GET_STATUS, 16'd0, 16'hFF02, 16'd2));
    put_setup(mk_setup(RT_INTF_OUT, usrh_pkg::RQ_CLEAR_FEATURE, 16'd0, 16'd2, 16'd0));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_DESCRIPTOR, {usrh_pkg::DT_DEVICE, 8'd0},
                       16'd0, 16'hFFFF));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_DESCRIPTOR, {usrh_pkg::DT_DEVICE, 8'd0},
                       16'd0, 16'd0));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_DESCRIPTOR, {usrh_pkg::DT_CONFIG, 8'd0},
                       16'd0, 16'hFFFF));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_DESCRIPTOR, {usrh_pkg::DT_CONFIG, 8'd2},
                       16'd0, 16'd5));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_DESCRIPTOR, {usrh_pkg::DT_STRING, 8'd3},
                       16'd0, 16'd255));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_DESCRIPTOR, {usrh_pkg::DT_STRING, 8'd4},
                       16'd0, 16'd255));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_DESCRIPTOR,
                       {usrh_pkg::DT_QUALIFIER, 8'd0}, 16'd0, 16'd64));
    put_setup(mk_setup(RT_DEV_IN, usrh_pkg::RQ_GET_DESCRIPTOR, {DT_INTERFACE, 8'd0},
                       16'd0, 16'd64));
    put_setup(mk_setup(RT_DEV_OUT, usrh_pkg::RQ_GET_DESCRIPTOR, {usrh_pkg::DT_DEVICE, 8'd0},
                       16'd0, 16'd64));
    put_setup(mk_setup(RT_INTF_OUT, usrh_pkg::RQ_SET_INTERFACE, 16'd1, 16'd2, 16'd0));
    drain();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: begin
          c.configuration_number       = 8'hFF;
          c.configuration_count        = 8'hFF;
          c.string_count               = 4'd8;
          c.interface_number           = 8'hFF;
          c.alternate_setting_value    = 8'hFF;
          c.configuration_total_length = 16'hFFFF;
          c.string_lengths             = '1;
        end
        1: begin
          c = '0;
          c.configuration_total_length = usrh_pkg::LEN_CONFIG;
        end
        2: begin
          // total length shorter than the configuration header
          c = rand_cfg();
          c.configuration_total_length = 16'($urandom_range(0, 8));
        end
        default: c = rand_cfg();
      endcase
      program_regs(c);
      if (ph == 3) hold_req = 1'b1;
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 50 == 0) begin
          idle_in  = $urandom_range(0, 3) != 0;
          idle_out = $urandom_range(0, 3) != 0;
        end
        // keep offering while the reply side is held off
        if (ph == 3 && k < 100) idle_in = 1'b0;
        put_setup(rand_setup());
      end
      drain();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/usrh_pkg.sv
hw/rtl/usrh_setup_if.sv
hw/rtl/usrh_result_if.sv
hw/rtl/usrh_cfg_regs.sv
hw/rtl/usrh_decode.sv
hw/rtl/usb_standard_request_handler.sv
dv/usrh_reply_checker.sv
dv/tb_usb_standard_request_handler.sv
